>>> design/qrs_pkg.sv
// package for the quadratic root solver: payload structs, widths, kind codes
// no dependencies
`default_nettype none
package qrs_pkg;
  localparam int unsigned TolWidth = 32;
  localparam logic [TolWidth-1:0] TolReset = 32'd4295;

  localparam logic [1:0] KindDouble  = 2'd0;
  localparam logic [1:0] KindReal    = 2'd1;
  localparam logic [1:0] KindComplex = 2'd2;
  localparam logic [1:0] KindAZero   = 2'd3;

  // sqrt of a 67-bit magnitude has 34 result bits
  localparam int unsigned MagWidth  = 67;
  localparam int unsigned RootWidth = 34;
  // numerator (-b plus or minus s) times 2^15: 35 + 15 = 50 bits signed
  localparam int unsigned NumWidth  = 50;
  localparam int unsigned QuoWidth  = 50;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] root1_real;
    logic signed [31:0] root1_imag;
    logic signed [31:0] root2_real;
    logic signed [31:0] root2_imag;
    logic [1:0]         root_kind;
    logic               saturated;
  } roots_t;
endpackage
`default_nettype wire

>>> design/qrs_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on qrs_pkg
`default_nettype none
module qrs_sqrt #(
  parameter int unsigned MW = qrs_pkg::MagWidth,
  parameter int unsigned RW = qrs_pkg::RootWidth,
  parameter int unsigned SW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [MW-1:0] in_mag,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [RW-1:0]      out_root,
  output logic [SW-1:0]      out_side
);
  // restoring method: remainder and partial root per stage
  logic [RW:0]     vld;
  logic [MW+1:0]   rem  [RW+1];
  logic [RW-1:0]   rt   [RW+1];
  logic [2*RW-1:0] src  [RW+1];
  logic [SW-1:0]   side [RW+1];

  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    rt[0]   = '0;
    src[0]  = (2*RW)'(in_mag);
    side[0] = in_side;
  end

  for (genvar g = 0; g < RW; g++) begin : g_step
    logic [MW+1:0] rsh;
    logic [MW+1:0] trial;
    always_comb begin
      rsh   = {rem[g][MW-1:0], src[g][2*RW-1 -: 2]};
      trial = {(MW+2-RW-2)'(0), rt[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else     vld[g+1] <= vld[g];
      src[g+1]  <= {src[g][2*RW-3:0], 2'b00};
      side[g+1] <= side[g];
      if (rsh >= trial) begin
        rem[g+1] <= rsh - trial;
        rt[g+1]  <= {rt[g][RW-2:0], 1'b1};
      end else begin
        rem[g+1] <= rsh;
        rt[g+1]  <= {rt[g][RW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = rt[RW];
  assign out_side  = side[RW];
endmodule
`default_nettype wire

>>> design/qrs_div.sv
// pipelined signed division, truncating toward zero, three lanes at once
// depends on qrs_pkg
`default_nettype none
module qrs_div #(
  parameter int unsigned NW = qrs_pkg::NumWidth,
  parameter int unsigned SW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic signed [NW-1:0] in_num [3],
  input  wire logic signed [32:0]   in_den,
  input  wire logic [SW-1:0]        in_side,
  output logic                      out_valid,
  output logic signed [NW-1:0]      out_quo [3],
  output logic [SW-1:0]             out_side
);
  // magnitudes, one quotient bit per stage, sign restored at the end
  logic [NW:0]   vld;
  logic [NW-1:0] nm   [NW+1][3];
  logic [NW-1:0] qq   [NW+1][3];
  logic [NW:0]   rr   [NW+1][3];
  logic [2:0]    ng   [NW+1];
  logic [32:0]   dm   [NW+1];
  logic [SW-1:0] side [NW+1];

  always_comb begin
    vld[0]  = in_valid;
    dm[0]   = in_den[32] ? 33'(-in_den) : 33'(in_den);
    side[0] = in_side;
    for (int l = 0; l < 3; l++) begin
      nm[0][l] = in_num[l][NW-1] ? NW'(-in_num[l]) : NW'(in_num[l]);
      qq[0][l] = '0;
      rr[0][l] = '0;
      ng[0][l] = in_num[l][NW-1] ^ in_den[32];
    end
  end

  for (genvar g = 0; g < NW; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else     vld[g+1] <= vld[g];
      dm[g+1]   <= dm[g];
      side[g+1] <= side[g];
      ng[g+1]   <= ng[g];
      for (int l = 0; l < 3; l++) begin
        nm[g+1][l] <= {nm[g][l][NW-2:0], 1'b0};
        if ({rr[g][l][NW-1:0], nm[g][l][NW-1]} >= (NW+1)'(dm[g])) begin
          rr[g+1][l] <= {rr[g][l][NW-1:0], nm[g][l][NW-1]} - (NW+1)'(dm[g]);
          qq[g+1][l] <= {qq[g][l][NW-2:0], 1'b1};
        end else begin
          rr[g+1][l] <= {rr[g][l][NW-1:0], nm[g][l][NW-1]};
          qq[g+1][l] <= {qq[g][l][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++)
      out_quo[l] = ng[NW][l] ? -$signed(qq[NW][l]) : $signed(qq[NW][l]);
  end
  assign out_valid = vld[NW];
  assign out_side  = side[NW];
endmodule
`default_nettype wire

>>> design/quadratic_root_solver_top.sv
// top level of the quadratic root solver: discriminant, sqrt and divide pipes
// depends on qrs_pkg, qrs_sqrt, qrs_div
`default_nettype none
// Usage: drive coef with a coefficient set and raise start; busy is always low,
// so one transfer is taken every cycle. The path holds 2 + 34 + 50 + 1 = 87
// register stages, the first loaded at the accepting edge; each result is on
// result with done high for one cycle, in order. The pipeline is fully
// pipelined: throughput is one item per cycle. The register depth is set by the
// square root (one stage per root bit) and the
// divider (one stage per quotient bit). The receiver cannot stall; results must
// be taken as they appear. tol_we writes the discriminant tolerance, taking
// effect for items accepted at the writing edge and after; reset sets it to
// 4295 and clears all valid bits in the pipeline, dropping items in flight.
// An a of zero yields kind 3 with all roots zero.
module quadratic_root_solver_top #(
  parameter logic [qrs_pkg::TolWidth-1:0] TOL_RESET = qrs_pkg::TolReset
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire qrs_pkg::coef_t               coef,
  output logic                              done,
  output qrs_pkg::roots_t                   result,
  input  wire logic                         tol_we,
  input  wire logic [qrs_pkg::TolWidth-1:0] tol_wdata
);
  localparam int unsigned MW = qrs_pkg::MagWidth;
  localparam int unsigned NW = qrs_pkg::NumWidth;

  logic [qrs_pkg::TolWidth-1:0] tol;
  always_ff @(posedge clk) begin
    if (rst)         tol <= TOL_RESET;
    else if (tol_we) tol <= tol_wdata;
  end
  assign busy = 1'b0;

  // stage 1: products of magnitudes
  logic        v1;
  logic [63:0] bb1, ac1;
  logic        acpos1;
  logic signed [31:0] a1, b1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    bb1    <= 64'(coef.coef_b[31] ? -33'(coef.coef_b) : 33'(coef.coef_b)) *
              64'(coef.coef_b[31] ? -33'(coef.coef_b) : 33'(coef.coef_b));
    ac1    <= 64'(coef.coef_a[31] ? -33'(coef.coef_a) : 33'(coef.coef_a)) *
              64'(coef.coef_c[31] ? -33'(coef.coef_c) : 33'(coef.coef_c));
    acpos1 <= (coef.coef_c != 0) && (coef.coef_a[31] == coef.coef_c[31]);
    a1     <= coef.coef_a;
    b1     <= coef.coef_b;
  end

  // stage 2: signed discriminant magnitude and classification
  logic        v2, neg2, dbl2;
  logic [MW-1:0] mag2;
  logic signed [31:0] a2, b2;
  logic [MW-1:0] bbx, acx, magc;
  logic          negc;
  always_comb begin
    bbx = MW'(bb1);
    acx = MW'({ac1, 2'b00});
    if (!acpos1)         begin magc = bbx + acx; negc = 1'b0; end
    else if (bbx >= acx) begin magc = bbx - acx; negc = 1'b0; end
    else                 begin magc = acx - bbx; negc = 1'b1; end
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    mag2 <= magc;
    neg2 <= negc;
    dbl2 <= (magc <= MW'(tol));
    a2   <= a1;
    b2   <= b1;
  end

  // square root, carrying a, b and flags
  logic        v3;
  logic [33:0] s3;
  logic [65:0] side3;
  qrs_sqrt #(.MW(MW), .RW(qrs_pkg::RootWidth), .SW(66)) u_sqrt (
    .clk(clk), .rst(rst), .in_valid(v2), .in_mag(mag2),
    .in_side({a2, b2, neg2, dbl2}),
    .out_valid(v3), .out_root(s3), .out_side(side3)
  );

  // numerators scaled by 2^15; for a complex pair lane 0 carries -b alone
  logic signed [31:0] a3, b3;
  logic               neg3, dbl3;
  logic signed [NW-1:0] num [3];
  logic signed [35:0]   nb, sx;
  assign {a3, b3, neg3, dbl3} = side3;
  always_comb begin
    nb = -36'(b3);
    sx = dbl3 ? 36'sd0 : $signed({2'b00, s3});
    num[0] = NW'(neg3 ? nb : nb + sx) <<< 15;
    num[1] = NW'(nb - sx) <<< 15;
    num[2] = NW'(sx) <<< 15;
  end

  // divider lanes: -b+s (or -b), -b-s, s
  logic                 v4;
  logic signed [NW-1:0] q [3];
  logic [2:0]           side4;
  qrs_div #(.NW(NW), .SW(3)) u_div (
    .clk(clk), .rst(rst), .in_valid(v3), .in_num(num),
    .in_den(33'(a3)), .in_side({a3 == 32'sd0, neg3, dbl3}),
    .out_valid(v4), .out_quo(q), .out_side(side4)
  );

  // final: ordering, saturation and output register
  function automatic logic [32:0] sat(input logic signed [NW-1:0] v);
    if (v > NW'(64'sd2147483647))       sat = {1'b1, 32'h7fffffff};
    else if (v < -NW'(64'sd2147483648)) sat = {1'b1, 32'h80000000};
    else                                sat = {1'b0, v[31:0]};
  endfunction

  qrs_pkg::roots_t rc;
  logic signed [NW-1:0] lo, hi, im;
  logic [32:0] s0, s1, s2, s3n, s4;
  always_comb begin
    lo  = (q[0] > q[1]) ? q[1] : q[0];
    hi  = (q[0] > q[1]) ? q[0] : q[1];
    im  = q[2][NW-1] ? -q[2] : q[2];
    s0  = sat(q[0]);
    s1  = sat(lo);
    s2  = sat(hi);
    s3n = sat(-im);
    s4  = sat(im);
    rc  = '0;
    if (side4[2]) begin
      rc.root_kind = qrs_pkg::KindAZero;
    end else if (side4[0]) begin
      rc.root_kind  = qrs_pkg::KindDouble;
      rc.root1_real = s0[31:0];
      rc.root2_real = s0[31:0];
      rc.saturated  = s0[32];
    end else if (!side4[1]) begin
      rc.root_kind  = qrs_pkg::KindReal;
      rc.root1_real = s1[31:0];
      rc.root2_real = s2[31:0];
      rc.saturated  = s1[32] | s2[32];
    end else begin
      rc.root_kind  = qrs_pkg::KindComplex;
      rc.root1_real = s0[31:0];
      rc.root2_real = s0[31:0];
      rc.root1_imag = s3n[31:0];
      rc.root2_imag = s4[31:0];
      rc.saturated  = s0[32] | s3n[32] | s4[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v4;
    result <= rc;
  end

  // a-zero results carry zero roots
  assert property (@(posedge clk) disable iff (rst)
    done && result.root_kind == qrs_pkg::KindAZero |->
      result.root1_real == 0 && result.root2_real == 0 && !result.saturated)
    else $error("a-zero result with nonzero roots");
  // real roots come in ascending order
  assert property (@(posedge clk) disable iff (rst)
    done && result.root_kind == qrs_pkg::KindReal |->
      result.root1_real <= result.root2_real)
    else $error("real roots out of order");
  // complex pair shares its real part
  assert property (@(posedge clk) disable iff (rst)
    done && result.root_kind == qrs_pkg::KindComplex |->
      result.root1_real == result.root2_real)
    else $error("complex pair real parts differ");
endmodule
`default_nettype wire
